FILE: hw/rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types and constants of the range minimum query table
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int CNT_W        = 11;
    localparam int EA_W         = 10;
    localparam int ELEM_W       = 32;
    localparam int ROW_LEN      = MAX_ELEMENTS + 2;
    localparam int LEVELS       = 11;
    localparam int TBL_DEPTH    = LEVELS * ROW_LEN;
    localparam int TBL_AW       = 14;
    localparam int LVL_W        = 4;
    localparam int CTR_W        = 12;

    localparam logic signed [ELEM_W-1:0] IDENTITY = 32'sh4000_0000;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_RANGE = 2'd1;
    localparam logic [1:0] ST_NOT_BUILT = 2'd2;

    typedef struct packed {
        logic                     command;
        logic signed [ELEM_W-1:0] element_value;
        logic                     last_element;
        logic [CNT_W-1:0]         query_left;
        logic [CNT_W-1:0]         query_right;
    } t_item;

    typedef struct packed {
        logic                     we;
        logic [TBL_AW-1:0]        addr;
        logic signed [ELEM_W-1:0] data;
    } t_tbl_wr;

endpackage

FILE: hw/rtl/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// request capture and two-entry queue toward the execution side
// ----------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_command,
    input  logic signed [ELEM_W-1:0] i_element_value,
    input  logic                     i_last_element,
    input  logic [CNT_W-1:0]         i_query_left,
    input  logic [CNT_W-1:0]         i_query_right,
    input  logic                     i_pop,
    output logic                     o_item_valid,
    output t_item                    o_item
);

    t_item      r_slot [2];
    logic       r_head, r_tail;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_pop;

    assign busy         = (r_cnt == 2'd2);
    assign w_push       = start && !busy;
    assign w_pop        = i_pop && (r_cnt != 2'd0);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_slot[r_head];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_tail <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_tail <= ~r_tail;
            end
            if (w_pop) begin
                r_head <= ~r_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_tail] <= '{command:       i_command,
                                element_value: i_element_value,
                                last_element:  i_last_element,
                                query_left:    i_query_left,
                                query_right:   i_query_right};
        end
    end

endmodule

FILE: hw/rtl/rmq_build.sv
// ----------------------------------------------------------------------------
// rmq_build
// table build sequencer: walks levels and block centres, writes suffix and
// prefix minima one entry per cycle
// ----------------------------------------------------------------------------
module rmq_build import rmq_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [CNT_W-1:0]         i_n,
    output logic [EA_W-1:0]          o_elem_addr,
    input  logic signed [ELEM_W-1:0] i_elem_data,
    output t_tbl_wr                  o_wr,
    output logic                     o_busy
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LEFT  = 3'b010,
        S_RIGHT = 3'b100
    } t_state;

    t_state                   r_state;
    logic [CTR_W-1:0]         r_n, r_w, r_i, r_x;
    logic [LVL_W-1:0]         r_k;
    logic                     r_b_valid, r_b_first;
    logic [CNT_W-1:0]         r_b_pos;
    logic [LVL_W-1:0]         r_b_lvl;
    logic signed [ELEM_W-1:0] r_run, w_run;
    logic [CTR_W-1:0]         w_m, w_i2, w_w2, w_idx;
    logic                     w_first, w_emit;

    assign w_emit  = (r_state != S_IDLE);
    assign w_first = (r_state == S_LEFT) ? (r_x == r_i - CTR_W'(1)) : (r_x == r_i);
    assign w_idx   = (r_state == S_LEFT) ? r_x : r_x - CTR_W'(2);
    assign w_m     = (r_i + r_w - CTR_W'(1) > r_n - CTR_W'(1)) ?
                     r_n - CTR_W'(1) : r_i + r_w - CTR_W'(1);
    assign w_i2    = r_i + {r_w[CTR_W-2:0], 1'b0};
    assign w_w2    = {r_w[CTR_W-2:0], 1'b0};

    assign o_elem_addr = w_idx[EA_W-1:0];
    assign o_busy      = w_emit || r_b_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start && (CTR_W'(i_n) > CTR_W'(2))) begin
                        r_state <= S_LEFT;
                    end
                end
                S_LEFT: begin
                    if (r_x == r_i - r_w) begin
                        r_state <= S_RIGHT;
                    end
                end
                S_RIGHT: begin
                    if (r_x == w_m && w_i2 >= r_n && w_w2 >= r_n) begin
                        r_state <= S_IDLE;
                    end else if (r_x == w_m) begin
                        r_state <= S_LEFT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_n <= CTR_W'(i_n);
                r_k <= LVL_W'(1);
                r_w <= CTR_W'(2);
                r_i <= CTR_W'(2);
                r_x <= CTR_W'(1);
            end
            S_LEFT: begin
                r_x <= (r_x == r_i - r_w) ? r_i : r_x - CTR_W'(1);
            end
            S_RIGHT: begin
                if (r_x != w_m) begin
                    r_x <= r_x + CTR_W'(1);
                end else if (w_i2 < r_n) begin
                    r_i <= w_i2;
                    r_x <= w_i2 - CTR_W'(1);
                end else begin
                    r_k <= r_k + LVL_W'(1);
                    r_w <= w_w2;
                    r_i <= w_w2;
                    r_x <= w_w2 - CTR_W'(1);
                end
            end
            default: r_x <= r_x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_first <= w_first;
        r_b_pos   <= r_x[CNT_W-1:0];
        r_b_lvl   <= r_k;
        if (r_b_valid) begin
            r_run <= w_run;
        end
    end

    assign w_run = r_b_first ? IDENTITY :
                   ((i_elem_data < r_run) ? i_elem_data : r_run);

    assign o_wr.we   = r_b_valid;
    assign o_wr.addr = TBL_AW'(r_b_lvl * TBL_AW'(ROW_LEN)) + TBL_AW'(r_b_pos);
    assign o_wr.data = w_run;

endmodule

FILE: hw/rtl/rmq_back.sv
// ----------------------------------------------------------------------------
// rmq_back
// execution side: element store, level table, loads, build and lookups
// ----------------------------------------------------------------------------
module rmq_back import rmq_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_item_valid,
    input  t_item                    i_item,
    output logic                     o_pop,
    output logic                     o_valid,
    output logic signed [ELEM_W-1:0] o_range_minimum,
    output logic [1:0]               o_query_status
);

    logic signed [ELEM_W-1:0] r_elem [MAX_ELEMENTS];
    logic signed [ELEM_W-1:0] r_tbl  [TBL_DEPTH];

    logic [CNT_W-1:0]         r_count, w_base;
    logic                     r_ready, r_build_go;
    logic [EA_W-1:0]          w_elem_addr;
    logic signed [ELEM_W-1:0] r_elem_data, r_ta, r_tb;
    t_tbl_wr                  w_wr;
    logic                     w_build_busy, w_load, w_query;
    logic [CNT_W-1:0]         w_hi, w_x;
    logic [LVL_W-1:0]         w_lvl;
    logic [1:0]               w_status;
    logic [TBL_AW-1:0]        w_row;
    logic                     r_q_valid, r_q_empty, r_o_valid;
    logic [1:0]               r_q_status, r_o_status;
    logic signed [ELEM_W-1:0] r_o_min;

    function automatic logic [LVL_W-1:0] top_bit(input logic [CNT_W-1:0] x);
        logic [LVL_W-1:0] b;
        b = '0;
        for (int k = 0; k < CNT_W; k++) begin
            if (x[k]) begin
                b = LVL_W'(k);
            end
        end
        return b;
    endfunction

    assign o_pop   = i_item_valid && !r_build_go && !w_build_busy;
    assign w_load  = o_pop && (i_item.command == CMD_LOAD);
    assign w_query = o_pop && (i_item.command == CMD_QUERY);
    assign w_base  = r_ready ? '0 : r_count;

    assign w_hi  = i_item.query_right + CNT_W'(1);
    assign w_x   = i_item.query_left ^ w_hi;
    assign w_lvl = top_bit(w_x);
    assign w_row = TBL_AW'(w_lvl * TBL_AW'(ROW_LEN));

    always_comb begin
        if (!r_ready) begin
            w_status = ST_NOT_BUILT;
        end else if (i_item.query_left > i_item.query_right ||
                     i_item.query_right > r_count) begin
            w_status = ST_BAD_RANGE;
        end else begin
            w_status = ST_OK;
        end
    end

    rmq_build u_build (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_build_go),
        .i_n         (r_count + CNT_W'(2)),
        .o_elem_addr (w_elem_addr),
        .i_elem_data (r_elem_data),
        .o_wr        (w_wr),
        .o_busy      (w_build_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ready    <= 1'b0;
            r_build_go <= 1'b0;
            r_q_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_build_go <= w_load && i_item.last_element;
            r_q_valid  <= w_query;
            r_o_valid  <= r_q_valid;
            if (w_load) begin
                r_count <= (w_base < CNT_W'(MAX_ELEMENTS)) ? w_base + CNT_W'(1) : w_base;
                r_ready <= i_item.last_element;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && (w_base < CNT_W'(MAX_ELEMENTS))) begin
            r_elem[w_base[EA_W-1:0]] <= i_item.element_value;
        end
        r_elem_data <= r_elem[w_elem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr.we) begin
            r_tbl[w_wr.addr] <= w_wr.data;
        end
        r_ta <= r_tbl[w_row + TBL_AW'(i_item.query_left)];
        r_tb <= r_tbl[w_row + TBL_AW'(w_hi)];
    end

    always_ff @(posedge i_clk) begin
        r_q_status <= w_status;
        r_q_empty  <= (i_item.query_left == i_item.query_right);
        r_o_status <= r_q_status;
        if (r_q_status != ST_OK) begin
            r_o_min <= '0;
        end else if (r_q_empty) begin
            r_o_min <= IDENTITY;
        end else begin
            r_o_min <= (r_ta < r_tb) ? r_ta : r_tb;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_range_minimum = r_o_min;
    assign o_query_status  = r_o_status;

endmodule

FILE: hw/rtl/range_min_query_table_core.sv
// ----------------------------------------------------------------------------
// range_min_query_table_core
// range minimum engine over a disjoint sparse table
// ----------------------------------------------------------------------------
// Loads and queries are taken one per cycle through a two-entry request queue
// while no build is running. After a query leaves the queue, its result is
// registered through a table read stage and a compare stage; o_valid is
// high for exactly one cycle and the result must be taken then. A load marked
// last starts the build, which writes one table entry per cycle through one
// table write port; requests wait in the queue while it runs, and busy rises
// once the queue holds two.
module range_min_query_table_core import rmq_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_command,
    input  logic signed [ELEM_W-1:0] i_element_value,
    input  logic                     i_last_element,
    input  logic [CNT_W-1:0]         i_query_left,
    input  logic [CNT_W-1:0]         i_query_right,
    output logic                     o_valid,
    output logic signed [ELEM_W-1:0] o_range_minimum,
    output logic [1:0]               o_query_status
);

    t_item w_item;
    logic  w_item_valid, w_pop;

    rmq_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_element_value (i_element_value),
        .i_last_element  (i_last_element),
        .i_query_left    (i_query_left),
        .i_query_right   (i_query_right),
        .i_pop           (w_pop),
        .o_item_valid    (w_item_valid),
        .o_item          (w_item)
    );

    rmq_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (w_item_valid),
        .i_item          (w_item),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .o_range_minimum (o_range_minimum),
        .o_query_status  (o_query_status)
    );

endmodule
